// ===== rtl/rts_pkg.sv =====
// Shared types and codes for the record table search/insert/delete unit.
// Holds request/response payloads, the record layout, codes and the FSM state type.
// No dependencies.
package rts_pkg;

    localparam int DEPTH_DEF = 64;

    localparam int KIND_W   = 2;
    localparam int KEY_W    = 32;
    localparam int AGE_W    = 8;
    localparam int LABEL_W  = 64;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 6;
    localparam int FILL_W   = 7;

    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [KEY_W-1:0]  key;
        logic [AGE_W-1:0]         age;
        logic [LABEL_W-1:0]       label;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [FILL_W-1:0]   fill;
    } rsp_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [AGE_W-1:0]        age;
        logic [LABEL_W-1:0]      label;
    } rec_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_SHIFT,
        S_REPLY
    } state_t;

    typedef struct packed {
        logic accept;
        logic do_insert;
        logic res_full;
        logic res_hit;
        logic res_miss;
        logic start_shift;
        logic step;
        logic shift_wr;
        logic dec_count;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic is_insert;
        logic is_delete;
        logic full;
        logic match;
        logic scan_end;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/rts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/rts_ctrl.sv =====
// Controller FSM for the record table: sequences dispatch, scan, shift and reply.
// Depends on rts_pkg (state, command and status types).
module rts_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  rts_pkg::sts_t sts,
    output rts_pkg::cmd_t cmd,
    output logic          busy
);

    rts_pkg::state_t state_reg;
    rts_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rts_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rts_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = rts_pkg::S_DISPATCH;
                end
            end
            rts_pkg::S_DISPATCH:
            begin
                state_next = sts.is_insert ? rts_pkg::S_REPLY : rts_pkg::S_SCAN;
            end
            rts_pkg::S_SCAN:
            begin
                if (sts.match)
                begin
                    state_next = sts.is_delete ? rts_pkg::S_SHIFT : rts_pkg::S_REPLY;
                end
                else if (sts.scan_end)
                begin
                    state_next = rts_pkg::S_REPLY;
                end
            end
            rts_pkg::S_SHIFT:
            begin
                if (sts.scan_end)
                begin
                    state_next = rts_pkg::S_REPLY;
                end
            end
            rts_pkg::S_REPLY:
            begin
                if (sts.out_free)
                begin
                    state_next = rts_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rts_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            rts_pkg::S_IDLE:
            begin
                cmd.accept = req_valid;
            end
            rts_pkg::S_DISPATCH:
            begin
                if (sts.is_insert)
                begin
                    cmd.res_full  = sts.full;
                    cmd.do_insert = !sts.full;
                end
            end
            rts_pkg::S_SCAN:
            begin
                if (sts.match)
                begin
                    cmd.res_hit     = 1'b1;
                    cmd.start_shift = sts.is_delete;
                end
                else if (sts.scan_end)
                begin
                    cmd.res_miss = 1'b1;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            rts_pkg::S_SHIFT:
            begin
                cmd.shift_wr = 1'b1;
                if (sts.scan_end)
                begin
                    cmd.dec_count = 1'b1;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            rts_pkg::S_REPLY:
            begin
                cmd.load_out = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign busy = (state_reg != rts_pkg::S_IDLE);

endmodule

// ===== rtl/rts_dp.sv =====
// Datapath for the record table: record RAM, fill count, scan pointer and result registers.
// Depends on rts_pkg and rts_ram.
module rts_dp #(
    parameter int DEPTH = rts_pkg::DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  rts_pkg::req_t req,
    input  rts_pkg::cmd_t cmd,
    output rts_pkg::sts_t sts,
    input  logic          rsp_stall,
    output logic          rsp_valid,
    output rts_pkg::rsp_t rsp
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int REC_W = $bits(rts_pkg::rec_t);

    rts_pkg::req_t               req_reg, req_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [CW-1:0]               ptr_reg, ptr_next;
    logic                        chk_vld_reg, chk_vld_next;
    logic [AW-1:0]               chk_idx_reg, chk_idx_next;
    logic [rts_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [AW-1:0]               res_slot_reg, res_slot_next;
    logic                        out_vld_reg, out_vld_next;
    rts_pkg::rsp_t               out_reg, out_next;

    logic [REC_W-1:0] rd_data;
    rts_pkg::rec_t    rd_rec;
    rts_pkg::rec_t    new_rec;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [REC_W-1:0] ram_wdata;
    logic             ptr_live;
    logic             full;
    logic             match;

    assign rd_rec   = rts_pkg::rec_t'(rd_data);
    assign ptr_live = (ptr_reg < count_reg);
    assign full     = (count_reg >= CW'(DEPTH));
    assign match    = chk_vld_reg && (rd_rec.key == req_reg.key);

    assign new_rec.key   = req_reg.key;
    assign new_rec.age   = req_reg.age;
    assign new_rec.label = req_reg.label;

    assign ram_we    = cmd.do_insert || (cmd.shift_wr && chk_vld_reg);
    assign ram_waddr = cmd.do_insert ? count_reg[AW-1:0] : (chk_idx_reg - AW'(1));
    assign ram_wdata = cmd.do_insert ? REC_W'(new_rec) : rd_data;

    rts_ram #(
        .WIDTH (REC_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ptr_reg[AW-1:0]),
        .rdata (rd_data)
    );

    always_comb
    begin
        req_next        = req_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        chk_vld_next    = chk_vld_reg;
        chk_idx_next    = chk_idx_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        out_vld_next    = out_vld_reg && rsp_stall;
        out_next        = out_reg;

        if (cmd.accept)
        begin
            req_next     = req;
            ptr_next     = '0;
            chk_vld_next = 1'b0;
        end
        else if (cmd.start_shift)
        begin
            ptr_next     = CW'(chk_idx_reg) + CW'(1);
            chk_vld_next = 1'b0;
        end
        else if (cmd.step)
        begin
            if (ptr_live)
            begin
                ptr_next     = ptr_reg + CW'(1);
                chk_vld_next = 1'b1;
                chk_idx_next = ptr_reg[AW-1:0];
            end
            else
            begin
                chk_vld_next = 1'b0;
            end
        end

        if (cmd.do_insert)
        begin
            count_next      = count_reg + CW'(1);
            res_status_next = rts_pkg::ST_DONE;
            res_slot_next   = count_reg[AW-1:0];
        end
        else if (cmd.dec_count)
        begin
            count_next = count_reg - CW'(1);
        end

        if (cmd.res_full)
        begin
            res_status_next = rts_pkg::ST_FULL;
            res_slot_next   = '0;
        end
        else if (cmd.res_hit)
        begin
            res_status_next = rts_pkg::ST_DONE;
            res_slot_next   = chk_idx_reg;
        end
        else if (cmd.res_miss)
        begin
            res_status_next = rts_pkg::ST_MISS;
            res_slot_next   = '0;
        end

        if (cmd.load_out)
        begin
            out_vld_next    = 1'b1;
            out_next.status = res_status_reg;
            out_next.slot   = rts_pkg::SLOT_W'(res_slot_reg);
            out_next.fill   = rts_pkg::FILL_W'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            ptr_reg     <= '0;
            chk_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            ptr_reg     <= ptr_next;
            chk_vld_reg <= chk_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        chk_idx_reg    <= chk_idx_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        out_reg        <= out_next;
    end

    assign sts.is_insert = (req_reg.kind == rts_pkg::KIND_INSERT);
    assign sts.is_delete = (req_reg.kind == rts_pkg::KIND_DELETE);
    assign sts.full      = full;
    assign sts.match     = match;
    assign sts.scan_end  = !ptr_live && !chk_vld_reg;
    assign sts.out_free  = !out_vld_reg || !rsp_stall;

    assign rsp_valid = out_vld_reg;
    assign rsp       = out_reg;

endmodule

// ===== rtl/record_table_search_insert_delete_unit.sv =====
// Record table unit: dense table of DEPTH records with linear search,
// append insert and compacting delete.
// Channels: req (kind, key, age, label) with req_valid/req_stall in; rsp
// (status, slot, fill) with rsp_valid/rsp_stall out. A request or response
// moves at a rising edge with valid high and stall low. One response per
// request, in order.
// An insert goes from dispatch straight to reply. The scan reads one RAM entry
// per cycle and a delete shifts the entries above the match right after it,
// one per cycle, so scan and shift together cover the table once. The scan
// runs on the registered RAM read and the scan pointer; one request is in work
// at a time, req_stall is high from acceptance until the response is loaded,
// and the next request can be taken in the following cycle.
// The response sits in an output register, so the next request is accepted
// while a finished response still waits; a stalled receiver holds the block
// only once a second response is ready.
// Reset empties the table (fill 0) and drops any pending response; the record
// RAM is not cleared since the scan never reads past the fill count.
// Depends on rts_pkg, rts_ctrl, rts_dp and rts_ram.
module record_table_search_insert_delete_unit #(
    parameter int DEPTH = rts_pkg::DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  rts_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output rts_pkg::rsp_t rsp
);

    rts_pkg::cmd_t cmd;
    rts_pkg::sts_t sts;
    logic          busy;

    rts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy)
    );

    rts_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    assign req_stall = busy;

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("block took a request but is not busy");

    a_slot_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != rts_pkg::ST_DONE) |-> (rsp.slot == '0))
        else $error("nonzero slot on a failed request");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status == rts_pkg::ST_DONE || rsp.status == rts_pkg::ST_MISS
                       || rsp.status == rts_pkg::ST_FULL))
        else $error("unknown status code");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (32'(rsp.fill) <= DEPTH))
        else $error("fill count above table depth");
`endif

endmodule

// ===== sim/tb_record_table_search_insert_delete_unit.sv =====
// Testbench for record_table_search_insert_delete_unit: a directed table followed by
// random search/insert/delete phases, each response checked against its scripted value
// or an in-bench table predictor. Depends on rts_pkg and the unit RTL.
module tb_record_table_search_insert_delete_unit;

    localparam int TABLE_DEPTH = rts_pkg::DEPTH_DEF;
    localparam logic [rts_pkg::KIND_W-1:0] KIND_RSVD = 2'd3;
    localparam int RAND_ITEMS = 1530;
    localparam int QUIET_ITEMS = 150;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 16;

    typedef enum int {
        MIX_FILL,
        MIX_BALANCED,
        MIX_DRAIN
    } mix_t;

    typedef struct packed {
        logic typed;
        rts_pkg::req_t cmd;
        rts_pkg::rsp_t want;
    } script_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    rts_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rts_pkg::rsp_t rsp;

    logic signed [rts_pkg::KEY_W-1:0] key_tab [TABLE_DEPTH];
    logic [rts_pkg::AGE_W-1:0] age_tab [TABLE_DEPTH];
    logic [rts_pkg::LABEL_W-1:0] label_tab [TABLE_DEPTH];
    int rec_count = 0;

    rts_pkg::rsp_t expected_rsp [$];
    rts_pkg::rsp_t want_rsp;
    int errors = 0;
    int cycles = 0;
    logic quiet = 1'b0;
    int tx_idle_pct = 20;
    int stall_pct = 0;
    int stall_left = 0;
    int stretch_left = 0;

    record_table_search_insert_delete_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    always #4 clk = ~clk;

    function automatic rts_pkg::rsp_t apply_record_op(input rts_pkg::req_t r);
        rts_pkg::rsp_t o;
        int hit;
        int i;
        o.status = rts_pkg::ST_MISS;
        o.slot = '0;
        hit = -1;
        if (r.kind == rts_pkg::KIND_INSERT)
        begin
            if (rec_count >= TABLE_DEPTH)
                o.status = rts_pkg::ST_FULL;
            else
            begin
                key_tab[rec_count] = r.key;
                age_tab[rec_count] = r.age;
                label_tab[rec_count] = r.label;
                o.slot = rts_pkg::SLOT_W'(rec_count);
                rec_count++;
                o.status = rts_pkg::ST_DONE;
            end
        end
        else
        begin
            for (i = 0; i < rec_count; i++)
                if (hit < 0 && key_tab[i] == r.key)
                    hit = i;
            if (hit >= 0)
            begin
                o.status = rts_pkg::ST_DONE;
                o.slot = rts_pkg::SLOT_W'(hit);
                if (r.kind == rts_pkg::KIND_DELETE)
                begin
                    for (i = hit; i + 1 < rec_count; i++)
                    begin
                        key_tab[i] = key_tab[i + 1];
                        age_tab[i] = age_tab[i + 1];
                        label_tab[i] = label_tab[i + 1];
                    end
                    rec_count--;
                end
            end
        end
        o.fill = rts_pkg::FILL_W'(rec_count);
        return o;
    endfunction

    function automatic rts_pkg::req_t pick_request(input mix_t mode);
        rts_pkg::req_t r;
        int p;
        int q;
        int ins_pct;
        int del_pct;
        ins_pct = (mode == MIX_FILL) ? 80 : (mode == MIX_BALANCED) ? 40 : 15;
        del_pct = (mode == MIX_FILL) ? 8 : (mode == MIX_BALANCED) ? 30 : 70;
        p = $urandom_range(99);
        if (p < ins_pct)
            r.kind = rts_pkg::KIND_INSERT;
        else if (p < ins_pct + del_pct)
            r.kind = rts_pkg::KIND_DELETE;
        else if (p < ins_pct + del_pct + 4)
            r.kind = KIND_RSVD;
        else
            r.kind = rts_pkg::KIND_SEARCH;
        q = $urandom_range(99);
        if (q < 50 && rec_count > 0)
            r.key = key_tab[$urandom_range(rec_count - 1)];
        else if (q < 85)
        begin
            r.key = $urandom_range(15);
            if ($urandom_range(1))
                r.key = ~r.key;
        end
        else
            r.key = $urandom;
        r.age = rts_pkg::AGE_W'($urandom);
        r.label = {$urandom, $urandom};
        return r;
    endfunction

    function automatic script_row_t script_row(input logic typed,
                                               input logic [rts_pkg::KIND_W-1:0] kind,
                                               input logic [rts_pkg::KEY_W-1:0] key,
                                               input logic [rts_pkg::AGE_W-1:0] age,
                                               input logic [rts_pkg::LABEL_W-1:0] label,
                                               input logic [rts_pkg::STATUS_W-1:0] status,
                                               input logic [rts_pkg::SLOT_W-1:0] slot,
                                               input logic [rts_pkg::FILL_W-1:0] fill);
        script_row_t s;
        s.typed = typed;
        s.cmd.kind = kind;
        s.cmd.key = key;
        s.cmd.age = age;
        s.cmd.label = label;
        s.want.status = status;
        s.want.slot = slot;
        s.want.fill = fill;
        return s;
    endfunction

    task automatic send_request(input rts_pkg::req_t r, input logic typed,
                                input rts_pkg::rsp_t typed_rsp);
        rts_pkg::rsp_t pred;
        if (!quiet && $urandom_range(99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        req <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pred = apply_record_op(r);
        expected_rsp.push_back(typed ? typed_rsp : pred);
    endtask

    always @(posedge clk)
    begin
        if (stretch_left == 0)
        begin
            stretch_left <= $urandom_range(20, 200);
            stall_pct <= 15 * $urandom_range(2);
        end
        else
            stretch_left <= stretch_left - 1;
        if (quiet)
        begin
            rsp_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(99) < stall_pct)
        begin
            rsp_stall <= 1'b1;
            stall_left <= $urandom_range(0, 11);
        end
        else
            rsp_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp.size() == 0)
            begin
                $display("%0t unexpected response: status %0d slot %0d fill %0d",
                         $time, rsp.status, rsp.slot, rsp.fill);
                errors++;
            end
            else
            begin
                want_rsp = expected_rsp.pop_front();
                if (rsp.status !== want_rsp.status || rsp.slot !== want_rsp.slot
                    || rsp.fill !== want_rsp.fill)
                begin
                    $display("%0t mismatch: expected status %0d slot %0d fill %0d,",
                             $time, want_rsp.status, want_rsp.slot, want_rsp.fill,
                             " got status %0d slot %0d fill %0d",
                             rsp.status, rsp.slot, rsp.fill);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        script_row_t dir_tab [20];
        int sent;
        int phase;
        int phase_len;
        int j;
        mix_t mode;
        dir_tab = '{
            script_row(1'b1, rts_pkg::KIND_SEARCH, 32'h0, 8'h00, 64'h0,
                       rts_pkg::ST_MISS, 6'd0, 7'd0),
            script_row(1'b1, rts_pkg::KIND_DELETE, 32'h0, 8'h00, 64'h0,
                       rts_pkg::ST_MISS, 6'd0, 7'd0),
            script_row(1'b1, KIND_RSVD, 32'h7FFFFFFF, 8'hFF, '1,
                       rts_pkg::ST_MISS, 6'd0, 7'd0),
            script_row(1'b1, rts_pkg::KIND_INSERT, 32'h80000000, 8'h00, 64'h0,
                       rts_pkg::ST_DONE, 6'd0, 7'd1),
            script_row(1'b1, rts_pkg::KIND_INSERT, 32'h7FFFFFFF, 8'hFF, '1,
                       rts_pkg::ST_DONE, 6'd1, 7'd2),
            script_row(1'b1, rts_pkg::KIND_INSERT, 32'hFFFFFFFF, 8'hA5, 64'h0123456789ABCDEF,
                       rts_pkg::ST_DONE, 6'd2, 7'd3),
            script_row(1'b1, rts_pkg::KIND_INSERT, 32'h7FFFFFFF, 8'h5A, 64'hFEDCBA9876543210,
                       rts_pkg::ST_DONE, 6'd3, 7'd4),
            script_row(1'b0, rts_pkg::KIND_SEARCH, 32'h7FFFFFFF, 8'h00, 64'h0,
                       rts_pkg::ST_DONE, 6'd0, 7'd0),
            script_row(1'b0, KIND_RSVD, 32'hFFFFFFFF, 8'h00, 64'h0,
                       rts_pkg::ST_DONE, 6'd0, 7'd0),
            script_row(1'b1, rts_pkg::KIND_SEARCH, 32'h0, 8'h00, 64'h0,
                       rts_pkg::ST_MISS, 6'd0, 7'd4),
            script_row(1'b0, rts_pkg::KIND_INSERT, 32'h0, 8'h01, 64'h1,
                       rts_pkg::ST_DONE, 6'd0, 7'd0),
            script_row(1'b0, rts_pkg::KIND_DELETE, 32'h7FFFFFFF, 8'h00, 64'h0,
                       rts_pkg::ST_DONE, 6'd0, 7'd0),
            script_row(1'b0, rts_pkg::KIND_SEARCH, 32'h7FFFFFFF, 8'h00, 64'h0,
                       rts_pkg::ST_DONE, 6'd0, 7'd0),
            script_row(1'b0, rts_pkg::KIND_DELETE, 32'h0, 8'h00, 64'h0,
                       rts_pkg::ST_DONE, 6'd0, 7'd0),
            script_row(1'b1, rts_pkg::KIND_DELETE, 32'd12345, 8'h00, 64'h0,
                       rts_pkg::ST_MISS, 6'd0, 7'd3),
            script_row(1'b0, rts_pkg::KIND_DELETE, 32'h80000000, 8'h00, 64'h0,
                       rts_pkg::ST_DONE, 6'd0, 7'd0),
            script_row(1'b0, rts_pkg::KIND_DELETE, 32'hFFFFFFFF, 8'h00, 64'h0,
                       rts_pkg::ST_DONE, 6'd0, 7'd0),
            script_row(1'b0, rts_pkg::KIND_DELETE, 32'h7FFFFFFF, 8'h00, 64'h0,
                       rts_pkg::ST_DONE, 6'd0, 7'd0),
            script_row(1'b1, rts_pkg::KIND_SEARCH, 32'h80000000, 8'h00, 64'h0,
                       rts_pkg::ST_MISS, 6'd0, 7'd0),
            script_row(1'b1, rts_pkg::KIND_INSERT, 32'h0, 8'h00, 64'h0,
                       rts_pkg::ST_DONE, 6'd0, 7'd1)
        };
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
            send_request(dir_tab[i].cmd, dir_tab[i].typed, dir_tab[i].want);

        sent = 0;
        phase = 0;
        while (sent < RAND_ITEMS)
        begin
            phase_len = (phase == 0) ? 160 : $urandom_range(40, 140);
            mode = (phase < 3) ? mix_t'(phase) : mix_t'($urandom_range(2));
            tx_idle_pct = 20 * $urandom_range(2);
            for (j = 0; j < phase_len && sent < RAND_ITEMS; j++)
            begin
                if (sent == RAND_ITEMS - QUIET_ITEMS)
                    quiet <= 1'b1;
                send_request(pick_request(mode), 1'b0, '0);
                sent++;
            end
            phase++;
        end
        req_valid <= 1'b0;

        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
